>>> design/sliding_window_axis_average_defines.svh
// Assertion macros for the sliding window average block.
// Included by the top level; defining NO_ASSERTIONS compiles them away.
`ifndef SLIDING_WINDOW_AXIS_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AXIS_AVERAGE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent holds in this cycle, consequent in the same cycle
`define SWAA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// antecedent holds in this cycle, consequent in the next one
`define SWAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SWAA_ASSERT_SAME(lbl, ante, cons)
`define SWAA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/swaa_pkg.sv
// Shared sizes, types and helper functions of the sliding window average.
// No dependencies; every module of the block imports this package.
package swaa_pkg;

  localparam int WINDOW_DEPTH = 128;
  localparam int SAMPLE_BITS  = 16;

  // port widths fixed by the interface
  localparam int IN_W   = 16;
  localparam int AVG_W  = 16;
  localparam int FILL_W = 8;

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int RAW_W  = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
  localparam int EXT_W  = (SUM_W > AVG_W) ? SUM_W : AVG_W;
  localparam int WORD_W = 3 * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [CNT_W-1:0]              count_t;
  typedef logic [PTR_W-1:0]              ptr_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // request accepted, latch payload and read the ring
    logic upd;        // push: update sums, ring, count and write position
    logic clear;      // clear: empty the window
    logic div_start;  // start the three dividers
    logic out_load;   // load the result register
  } swaa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;   // latched request is a clear
    logic div_busy;   // dividers still iterating
  } swaa_sts_t;

  // sample taken from the low SAMPLE_BITS of the field
  function automatic sample_t sext_sample(logic [IN_W-1:0] raw);
    logic [RAW_W-1:0] v;
    v = RAW_W'(raw);
    return sample_t'(v[SAMPLE_BITS-1:0]);
  endfunction

  // low AVG_W bits of a sign-extended quotient
  function automatic logic [AVG_W-1:0] avg_bits(sum_t q);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(q);
    return e[AVG_W-1:0];
  endfunction

endpackage

>>> design/sliding_window_axis_average.sv
// Sliding window three-axis average (boxcar filter). Each push request stores one
// signed sample per axis in a ring of WINDOW_DEPTH entries and returns the per-axis
// window average, truncated toward zero, with the fill count. A push is resolved by
// bit-per-cycle restoring dividers, one per axis, running in parallel; a clear
// request returns zeros with avg_valid low. The next request is accepted once the
// result is in the output register, while it waits to be taken.
// Built from swaa_ctrl, swaa_dp and swaa_div; depends on swaa_pkg.
`include "sliding_window_axis_average_defines.svh"
module sliding_window_axis_average (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic signed [swaa_pkg::IN_W-1:0]  in_accel_x,
  input  logic signed [swaa_pkg::IN_W-1:0]  in_accel_y,
  input  logic signed [swaa_pkg::IN_W-1:0]  in_accel_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [swaa_pkg::AVG_W-1:0] out_avg_x,
  output logic signed [swaa_pkg::AVG_W-1:0] out_avg_y,
  output logic signed [swaa_pkg::AVG_W-1:0] out_avg_z,
  output logic [swaa_pkg::FILL_W-1:0] out_fill_count,
  output logic                        out_avg_valid
);
  import swaa_pkg::*;

  swaa_cmd_t cmd;
  swaa_sts_t sts;

  swaa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swaa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req_type(in_req_type),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .avg_x      (out_avg_x),
    .avg_y      (out_avg_y),
    .avg_z      (out_avg_z),
    .fill_count (out_fill_count),
    .avg_valid  (out_avg_valid)
  );

  // one request in flight at a time
  `SWAA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // a result never overwrites one that has not been taken
  `SWAA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready)
  // dividers are idle when started
  `SWAA_ASSERT_SAME(a_div_idle, cmd.div_start, !sts.div_busy)

endmodule

>>> design/swaa_div.sv
// Signed by unsigned restoring divider, one quotient bit per cycle.
// Quotient truncates toward zero. Depends on swaa_pkg.
module swaa_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  swaa_pkg::sum_t   dividend,
  input  swaa_pkg::count_t divisor,
  output logic            busy,
  output swaa_pkg::sum_t   quotient
);
  import swaa_pkg::*;

  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic               neg_r;
  logic [SUM_W-1:0]   q_r;
  count_t             rem_r;
  count_t             div_r;

  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_sub;
  logic               q_bit;
  logic [SUM_W-1:0]   mag;

  // magnitude of the dividend; the most negative value still fits unsigned
  assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, q_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    q_bit   = (rem_sh >= {1'b0, div_r});
  end

  // control: step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(SUM_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: quotient shifts in over the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= mag;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -sum_t'(q_r) : sum_t'(q_r);

endmodule

>>> design/swaa_ctrl.sv
// Sequencer of the sliding window average: handshakes and step order.
// Depends on swaa_pkg; drives the datapath through swaa_cmd_t.
module swaa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  swaa_pkg::swaa_sts_t sts,
  output swaa_pkg::swaa_cmd_t cmd
);
  import swaa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // result register can take a new value
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.take      = (state_r == S_IDLE) && in_valid;
    cmd.upd       = (state_r == S_UPD) && !sts.is_clear;
    cmd.clear     = (state_r == S_UPD) && sts.is_clear;
    cmd.div_start = (state_r == S_DIV_GO);
    cmd.out_load  = (state_r == S_OUT) && out_free;
  end

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= sts.is_clear ? S_OUT : S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!sts.div_busy) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/swaa_dp.sv
// Datapath of the sliding window average: sample ring, running sums,
// fill count, three dividers and the result register. Depends on swaa_pkg.
module swaa_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swaa_pkg::swaa_cmd_t    cmd,
  output swaa_pkg::swaa_sts_t    sts,
  input  logic                   in_req_type,
  input  logic [swaa_pkg::IN_W-1:0] in_accel_x,
  input  logic [swaa_pkg::IN_W-1:0] in_accel_y,
  input  logic [swaa_pkg::IN_W-1:0] in_accel_z,
  output logic [swaa_pkg::AVG_W-1:0] avg_x,
  output logic [swaa_pkg::AVG_W-1:0] avg_y,
  output logic [swaa_pkg::AVG_W-1:0] avg_z,
  output logic [swaa_pkg::FILL_W-1:0] fill_count,
  output logic                   avg_valid
);
  import swaa_pkg::*;

  logic [WORD_W-1:0] ring [WINDOW_DEPTH];
  logic [WORD_W-1:0] rd_r;

  logic    clr_r;
  sample_t smp_x_r, smp_y_r, smp_z_r;
  sum_t    sum_x_r, sum_y_r, sum_z_r;
  sum_t    sum_x_nxt, sum_y_nxt, sum_z_nxt;
  count_t  count_r;
  ptr_t    wp_r;
  logic    full;

  sum_t    q_x, q_y, q_z;
  logic    busy_x, busy_y, busy_z;

  logic [AVG_W-1:0]  avg_x_r, avg_y_r, avg_z_r;
  logic [FILL_W-1:0] fill_r;
  logic              valid_r;

  // latch the request and read the slot that the push will replace
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      clr_r   <= in_req_type;
      smp_x_r <= sext_sample(in_accel_x);
      smp_y_r <= sext_sample(in_accel_y);
      smp_z_r <= sext_sample(in_accel_z);
      rd_r    <= ring[wp_r];
    end
  end

  // ring write, word layout {z, y, x}
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      ring[wp_r] <= {smp_z_r, smp_y_r, smp_x_r};
    end
  end

  assign full = (count_r == count_t'(WINDOW_DEPTH));

  // running sums: drop the oldest sample once the window is full
  always_comb begin
    sum_x_nxt = sum_x_r + sum_t'(smp_x_r);
    sum_y_nxt = sum_y_r + sum_t'(smp_y_r);
    sum_z_nxt = sum_z_r + sum_t'(smp_z_r);
    if (full) begin
      sum_x_nxt = sum_x_nxt - sum_t'(sample_t'(rd_r[SAMPLE_BITS-1:0]));
      sum_y_nxt = sum_y_nxt - sum_t'(sample_t'(rd_r[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      sum_z_nxt = sum_z_nxt - sum_t'(sample_t'(rd_r[3*SAMPLE_BITS-1:2*SAMPLE_BITS]));
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      count_r <= '0;
      wp_r    <= '0;
    end else if (cmd.upd) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
      if (!full) begin
        count_r <= count_r + 1'b1;
      end
      wp_r <= (wp_r == ptr_t'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
  end

  // one divider lane per axis, all started together
  swaa_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(sum_x_r), .divisor(count_r), .busy(busy_x), .quotient(q_x)
  );
  swaa_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(sum_y_r), .divisor(count_r), .busy(busy_y), .quotient(q_y)
  );
  swaa_div u_div_z (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(sum_z_r), .divisor(count_r), .busy(busy_z), .quotient(q_z)
  );

  assign sts.is_clear = clr_r;
  assign sts.div_busy = busy_x || busy_y || busy_z;

  // result register; a clear reports all zeros
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (clr_r) begin
        avg_x_r <= '0;
        avg_y_r <= '0;
        avg_z_r <= '0;
        fill_r  <= '0;
        valid_r <= 1'b0;
      end else begin
        avg_x_r <= avg_bits(q_x);
        avg_y_r <= avg_bits(q_y);
        avg_z_r <= avg_bits(q_z);
        fill_r  <= FILL_W'(count_r);
        valid_r <= 1'b1;
      end
    end
  end

  assign avg_x      = avg_x_r;
  assign avg_y      = avg_y_r;
  assign avg_z      = avg_z_r;
  assign fill_count = fill_r;
  assign avg_valid  = valid_r;

endmodule

>>> sim/sliding_window_axis_average_test.sv
// Self-checking testbench for the sliding window three-axis average block.
// Directed table then random push/clear bursts, checked against a local window model.
// Depends on swaa_pkg and the sliding_window_axis_average top level.
module sliding_window_axis_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swaa_pkg::*;

  localparam bit REQ_PUSH  = 1'b0;
  localparam bit REQ_CLEAR = 1'b1;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = SUM_W + 16;

  typedef struct packed {
    logic [AVG_W-1:0]  ax;
    logic [AVG_W-1:0]  ay;
    logic [AVG_W-1:0]  az;
    logic [FILL_W-1:0] fill;
    logic              valid;
  } window_avg_t;

  typedef struct {
    bit          clr;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    bit          typed;
    window_avg_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic signed [IN_W-1:0] in_accel_x = '0;
  logic signed [IN_W-1:0] in_accel_y = '0;
  logic signed [IN_W-1:0] in_accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AVG_W-1:0] out_avg_x;
  logic signed [AVG_W-1:0] out_avg_y;
  logic signed [AVG_W-1:0] out_avg_z;
  logic [FILL_W-1:0] out_fill_count;
  logic out_avg_valid;

  // model of the window: ring, running sums, write slot and count
  longint      window_ring [WINDOW_DEPTH][3];
  longint      window_sums [3];
  int          window_slot;
  int          window_held;

  window_avg_t pending_averages[$];
  int          mismatch_count;
  int          cycle_count;
  bit          calm = 1'b0;

  sliding_window_axis_average dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_avg_x      (out_avg_x),
    .out_avg_y      (out_avg_y),
    .out_avg_z      (out_avg_z),
    .out_fill_count (out_fill_count),
    .out_avg_valid  (out_avg_valid)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic flag_error(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // next window average for one request; updates the model state
  function automatic window_avg_t predict_window_average(bit clr, logic [15:0] x,
                                                          logic [15:0] y, logic [15:0] z);
    window_avg_t r;
    logic [15:0] raw [3];
    logic signed [SAMPLE_BITS-1:0] s;
    logic [AVG_W-1:0] avg [3];
    longint q;
    int slot;
    r = '0;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    if (clr) begin
      for (int a = 0; a < 3; a++) window_sums[a] = 0;
      window_slot = 0;
      window_held = 0;
      return r;
    end
    slot = (window_slot >= WINDOW_DEPTH) ? 0 : window_slot;
    // full window: drop the oldest sample, which sits in the slot being written
    if (window_held >= WINDOW_DEPTH) begin
      for (int a = 0; a < 3; a++) window_sums[a] -= window_ring[slot][a];
      window_held = WINDOW_DEPTH;
    end else begin
      window_held++;
    end
    for (int a = 0; a < 3; a++) begin
      s = raw[a][SAMPLE_BITS-1:0];
      window_ring[slot][a] = longint'(s);
      window_sums[a] += longint'(s);
    end
    window_slot = (slot + 1 >= WINDOW_DEPTH) ? 0 : slot + 1;
    // divide truncates toward zero
    for (int a = 0; a < 3; a++) begin
      q = window_sums[a] / longint'(window_held);
      avg[a] = q[AVG_W-1:0];
    end
    r.ax = avg[0];
    r.ay = avg[1];
    r.az = avg[2];
    r.fill = window_held[FILL_W-1:0];
    r.valid = 1'b1;
    return r;
  endfunction

  // present one request, hold it until accepted, then queue its expected average
  task automatic send_request(bit clr, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              bit typed = 1'b0, window_avg_t want = '0);
    window_avg_t pred;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= clr;
    in_accel_x  <= x;
    in_accel_y  <= y;
    in_accel_z  <= z;
    do @(posedge clk); while (!in_ready);
    pred = predict_window_average(clr, x, y, z);
    pending_averages.push_back(typed ? want : pred);
  endtask

  // hold off the sender until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_averages.size() != 0);
  endtask

  function automatic logic [15:0] draw_axis(int kind, logic [15:0] fixed);
    case (kind)
      0: return fixed;
      1: return 16'($urandom);
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return fixed ^ 16'($urandom_range(0, 3));
    endcase
  endfunction

  // result side stalls about 8 percent of the time, never during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  // compare each taken result with the oldest expected average
  always @(posedge clk) begin : check_results
    window_avg_t got;
    window_avg_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_avg_x, out_avg_y, out_avg_z, out_fill_count, out_avg_valid};
      if (pending_averages.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        want = pending_averages.pop_front();
        if (got.ax !== want.ax)
          flag_error($sformatf("avg_x got %0d want %0d", $signed(got.ax), $signed(want.ax)));
        if (got.ay !== want.ay)
          flag_error($sformatf("avg_y got %0d want %0d", $signed(got.ay), $signed(want.ay)));
        if (got.az !== want.az)
          flag_error($sformatf("avg_z got %0d want %0d", $signed(got.az), $signed(want.az)));
        if (got.fill !== want.fill)
          flag_error($sformatf("fill_count got %0d want %0d", got.fill, want.fill));
        if (got.valid !== want.valid)
          flag_error($sformatf("avg_valid got %b want %b", got.valid, want.valid));
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    logic [15:0] fixed [3];
    int sent;
    int kind;
    int len;
    bit clr;
    mismatch_count = 0;
    cycle_count = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++)
      for (int a = 0; a < 3; a++) window_ring[i][a] = 0;
    for (int a = 0; a < 3; a++) window_sums[a] = 0;
    window_slot = 0;
    window_held = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, truncation toward zero, clear of a partly filled and an empty window
    rows = '{
      '{REQ_PUSH,  16'h7fff, 16'h8000, 16'h0000, 1'b1,
        '{16'h7fff, 16'h8000, 16'h0000, 8'd1, 1'b1}},
      '{REQ_PUSH,  16'h7fff, 16'h8000, 16'h0001, 1'b0, '0},
      '{REQ_PUSH,  16'hffff, 16'h0001, 16'hffff, 1'b0, '0},
      '{REQ_CLEAR, 16'hffff, 16'hffff, 16'hffff, 1'b1, '0},
      '{REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
      '{REQ_PUSH,  16'h8000, 16'h7fff, 16'hffff, 1'b1,
        '{16'h8000, 16'h7fff, 16'hffff, 8'd1, 1'b1}},
      '{REQ_PUSH,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_PUSH,  16'h0001, 16'h0002, 16'h0003, 1'b0, '0},
      '{REQ_CLEAR, 16'h5555, 16'haaaa, 16'h8001, 1'b1, '0},
      '{REQ_PUSH,  16'hfff9, 16'h0007, 16'hfffd, 1'b1,
        '{16'hfff9, 16'h0007, 16'hfffd, 8'd1, 1'b1}},
      '{REQ_PUSH,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_PUSH,  16'h5555, 16'haaaa, 16'h8001, 1'b0, '0},
      '{REQ_PUSH,  16'hffff, 16'hffff, 16'hffff, 1'b0, '0},
      '{REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0}
    };
    foreach (rows[r])
      send_request(rows[r].clr, rows[r].x, rows[r].y, rows[r].z, rows[r].typed, rows[r].want);
    wait_drained();

    // random bursts of pushes, some long enough to wrap the ring, mostly closed by a clear
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 3);
      len = $urandom_range(1, 320);
      for (int a = 0; a < 3; a++) fixed[a] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        calm <= (sent >= 300 && sent < 500);
        if (sent == 450) wait_drained();
        // stray clear in the middle of a burst
        clr = ($urandom_range(199) == 0) ? REQ_CLEAR : REQ_PUSH;
        send_request(clr, draw_axis(kind, fixed[0]), draw_axis(kind, fixed[1]),
                     draw_axis(kind, fixed[2]));
        sent++;
      end
      if ($urandom_range(99) < 60) begin
        send_request(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
